/* rtl/rv64i_subset_instruction_decoder_core_defines.svh */
// Assertion macros for the instruction decoder RTL.
`ifndef RV64I_SUBSET_INSTRUCTION_DECODER_CORE_DEFINES_SVH
`define RV64I_SUBSET_INSTRUCTION_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset
`define RVD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, checked on every rising edge outside reset
`define RVD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RVD_ASSERT_IMP(lbl, ante, cons)
`define RVD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/rvd_pkg.sv */
// Types and constants of the RV64I subset instruction decoder.
`timescale 1ns / 1ps

package rvd_pkg;

    // Major opcodes
    localparam logic [6:0] OP_RALU   = 7'b0110011;
    localparam logic [6:0] OP_IALU   = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;

    // funct7 for sub / sra
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    // funct6 for srai
    localparam logic [5:0] F6_SRAI   = 6'b010000;

    // Dense mnemonic codes
    typedef enum logic [5:0] {
        MN_ADD   = 6'd0,  MN_XOR   = 6'd1,  MN_OR    = 6'd2,  MN_AND   = 6'd3,
        MN_SLL   = 6'd4,  MN_SRL   = 6'd5,  MN_SLT   = 6'd6,  MN_SLTU  = 6'd7,
        MN_SUB   = 6'd8,  MN_SRA   = 6'd9,
        MN_ADDI  = 6'd10, MN_XORI  = 6'd11, MN_ORI   = 6'd12, MN_ANDI  = 6'd13,
        MN_SLLI  = 6'd14, MN_SRLI  = 6'd15, MN_SRAI  = 6'd16, MN_SLTI  = 6'd17,
        MN_SLTIU = 6'd18,
        MN_LB    = 6'd19, MN_LH    = 6'd20, MN_LW    = 6'd21, MN_LD    = 6'd22,
        MN_LBU   = 6'd23, MN_LHU   = 6'd24, MN_LWU   = 6'd25,
        MN_JALR  = 6'd26,
        MN_SB    = 6'd27, MN_SH    = 6'd28, MN_SW    = 6'd29, MN_SD    = 6'd30,
        MN_BEQ   = 6'd31, MN_BNE   = 6'd32, MN_BLT   = 6'd33, MN_BGE   = 6'd34,
        MN_BLTU  = 6'd35, MN_BGEU  = 6'd36,
        MN_JAL   = 6'd37, MN_LUI   = 6'd38
    } mnem_t;

    // Decoded fields of one instruction
    typedef struct packed {
        logic               valid;
        mnem_t              mnemonic;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic signed [20:0] imm;
        logic               has_target;
    } dec_t;

endpackage

/* rtl/rvd_decode.sv */
// Combinational field decode of one instruction word.
`timescale 1ns / 1ps

module rvd_decode
    import rvd_pkg::*;
(
    input  logic [31:0] instr,
    output dec_t        dec
);

    logic [6:0]         op;
    logic [2:0]         f3;
    logic [6:0]         f7;
    logic [5:0]         f6;
    logic signed [20:0] imm_i;
    logic signed [20:0] imm_sh;
    logic signed [20:0] imm_s;
    logic signed [20:0] imm_b;
    logic signed [20:0] imm_j;
    logic signed [20:0] imm_u;
    dec_t               raw;

    assign op = instr[6:0];
    assign f3 = instr[14:12];
    assign f7 = instr[31:25];
    assign f6 = instr[31:26];

    // Immediate formats, sign-extended to 21 bits (shift amounts are zero-extended, lui keeps raw upper bits)
    assign imm_i  = {{9{instr[31]}}, instr[31:20]};
    assign imm_sh = {15'd0, instr[25:20]};
    assign imm_s  = {{9{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b  = {{8{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_j  = {instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    assign imm_u  = {1'b0, instr[31:12]};

    // Opcode / funct decode
    always_comb
    begin
        raw            = '0;
        raw.mnemonic   = MN_ADD;
        case (op)
            OP_RALU:
            begin
                raw.rd  = instr[11:7];
                raw.rs1 = instr[19:15];
                raw.rs2 = instr[24:20];
                if (f7 == 7'd0)
                begin
                    raw.valid = 1'b1;
                    case (f3)
                        3'd0:    raw.mnemonic = MN_ADD;
                        3'd1:    raw.mnemonic = MN_SLL;
                        3'd2:    raw.mnemonic = MN_SLT;
                        3'd3:    raw.mnemonic = MN_SLTU;
                        3'd4:    raw.mnemonic = MN_XOR;
                        3'd5:    raw.mnemonic = MN_SRL;
                        3'd6:    raw.mnemonic = MN_OR;
                        default: raw.mnemonic = MN_AND;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == 3'd0)
                begin
                    raw.valid    = 1'b1;
                    raw.mnemonic = MN_SUB;
                end
                else if (f7 == F7_ALT && f3 == 3'd5)
                begin
                    raw.valid    = 1'b1;
                    raw.mnemonic = MN_SRA;
                end
            end
            OP_IALU:
            begin
                raw.rd  = instr[11:7];
                raw.rs1 = instr[19:15];
                raw.imm = imm_i;
                case (f3)
                    3'd1:
                    begin
                        raw.imm = imm_sh;
                        if (f6 == 6'd0)
                        begin
                            raw.valid    = 1'b1;
                            raw.mnemonic = MN_SLLI;
                        end
                    end
                    3'd5:
                    begin
                        raw.imm = imm_sh;
                        if (f6 == 6'd0)
                        begin
                            raw.valid    = 1'b1;
                            raw.mnemonic = MN_SRLI;
                        end
                        else if (f6 == F6_SRAI)
                        begin
                            raw.valid    = 1'b1;
                            raw.mnemonic = MN_SRAI;
                        end
                    end
                    3'd0:
                    begin
                        raw.valid    = 1'b1;
                        raw.mnemonic = MN_ADDI;
                    end
                    3'd2:
                    begin
                        raw.valid    = 1'b1;
                        raw.mnemonic = MN_SLTI;
                    end
                    3'd3:
                    begin
                        raw.valid    = 1'b1;
                        raw.mnemonic = MN_SLTIU;
                    end
                    3'd4:
                    begin
                        raw.valid    = 1'b1;
                        raw.mnemonic = MN_XORI;
                    end
                    3'd6:
                    begin
                        raw.valid    = 1'b1;
                        raw.mnemonic = MN_ORI;
                    end
                    default:
                    begin
                        raw.valid    = 1'b1;
                        raw.mnemonic = MN_ANDI;
                    end
                endcase
            end
            OP_LOAD:
            begin
                raw.rd    = instr[11:7];
                raw.rs1   = instr[19:15];
                raw.imm   = imm_i;
                raw.valid = 1'b1;
                case (f3)
                    3'd0:    raw.mnemonic = MN_LB;
                    3'd1:    raw.mnemonic = MN_LH;
                    3'd2:    raw.mnemonic = MN_LW;
                    3'd3:    raw.mnemonic = MN_LD;
                    3'd4:    raw.mnemonic = MN_LBU;
                    3'd5:    raw.mnemonic = MN_LHU;
                    3'd6:    raw.mnemonic = MN_LWU;
                    default: raw.valid    = 1'b0;
                endcase
            end
            OP_JALR:
            begin
                raw.rd       = instr[11:7];
                raw.rs1      = instr[19:15];
                raw.imm      = imm_i;
                raw.valid    = (f3 == 3'd0);
                raw.mnemonic = MN_JALR;
            end
            OP_STORE:
            begin
                raw.rs1   = instr[19:15];
                raw.rs2   = instr[24:20];
                raw.imm   = imm_s;
                raw.valid = 1'b1;
                case (f3)
                    3'd0:    raw.mnemonic = MN_SB;
                    3'd1:    raw.mnemonic = MN_SH;
                    3'd2:    raw.mnemonic = MN_SW;
                    3'd3:    raw.mnemonic = MN_SD;
                    default: raw.valid    = 1'b0;
                endcase
            end
            OP_BRANCH:
            begin
                raw.rs1        = instr[19:15];
                raw.rs2        = instr[24:20];
                raw.imm        = imm_b;
                raw.valid      = 1'b1;
                raw.has_target = 1'b1;
                case (f3)
                    3'd0:    raw.mnemonic = MN_BEQ;
                    3'd1:    raw.mnemonic = MN_BNE;
                    3'd4:    raw.mnemonic = MN_BLT;
                    3'd5:    raw.mnemonic = MN_BGE;
                    3'd6:    raw.mnemonic = MN_BLTU;
                    3'd7:    raw.mnemonic = MN_BGEU;
                    default: raw.valid    = 1'b0;
                endcase
            end
            OP_JAL:
            begin
                raw.rd         = instr[11:7];
                raw.imm        = imm_j;
                raw.valid      = 1'b1;
                raw.has_target = 1'b1;
                raw.mnemonic   = MN_JAL;
            end
            OP_LUI:
            begin
                raw.rd       = instr[11:7];
                raw.imm      = imm_u;
                raw.valid    = 1'b1;
                raw.mnemonic = MN_LUI;
            end
            default:
            begin
                raw.valid = 1'b0;
            end
        endcase
    end

    // Unrecognized words report all-zero fields
    always_comb
    begin
        dec          = raw;
        if (!raw.valid)
        begin
            dec          = '0;
            dec.mnemonic = MN_ADD;
        end
    end

endmodule

/* rtl/rv64i_subset_instruction_decoder_core.sv */
// Top level of the RV64I subset instruction decoder: input stage, pc, result register.
//
//  channel   dir  signals                         contents
//  s_axis    in   tvalid tready tdata[31:0]       instr_word
//  m_axis    out  tvalid tready tdata[111:0] tuser[1:0]  decoded instruction
//
//  One transaction per clock in each direction while the output is not stalled.
//  A word taken is held in the input register, then loaded into the result
//  register, and is on the output from then on.
//  The pc increment feeds back into the pc register.
//  Reset clears the pc to zero and empties both stages.
//  A stalled output holds its result; the input stage still takes a word while
//  it is empty or while its word moves on to the result register in that cycle.
`timescale 1ns / 1ps
`include "rv64i_subset_instruction_decoder_core_defines.svh"

module rv64i_subset_instruction_decoder_core
    import rvd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] instr_word
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [5:0] mnemonic, [10:6] rd_index, [15:11] rs1_index, [20:16] rs2_index,
    // [41:21] immediate, [73:42] instr_addr, [105:74] target_addr, [111:106] zero
    output logic [111:0] m_axis_tdata,
    // [0] valid_res, [1] has_target
    output logic [1:0]   m_axis_tuser
);

    logic        in_acc;
    logic        out_free;
    logic        s1_move;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_word_reg;
    logic [31:0] s1_addr_reg;
    logic [31:0] pc_reg;
    logic [31:0] pc_next;

    dec_t        dec;
    logic [31:0] target_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    dec_t        out_dec_reg;
    logic [31:0] out_addr_reg;
    logic [31:0] out_target_reg;

    // Handshake control
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign pc_next        = pc_reg + 32'd4;
    assign s1_valid_next  = in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                pc_reg <= pc_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input stage payload: word and its address
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_word_reg <= s_axis_tdata;
            s1_addr_reg <= pc_reg;
        end
    end

    rvd_decode u_decode (
        .instr (s1_word_reg),
        .dec   (dec)
    );

    // Branch / jal target, wraps modulo 2^32
    assign target_next = dec.has_target
                       ? s1_addr_reg + {{11{dec.imm[20]}}, dec.imm}
                       : 32'd0;

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_dec_reg    <= dec;
            out_addr_reg   <= s1_addr_reg;
            out_target_reg <= target_next;
        end
    end

    // Output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_target_reg, out_addr_reg, out_dec_reg.imm,
                            out_dec_reg.rs2, out_dec_reg.rs1, out_dec_reg.rd,
                            out_dec_reg.mnemonic};
    assign m_axis_tuser  = {out_dec_reg.has_target, out_dec_reg.valid};

    // Checks
    `RVD_ASSERT_NXT(a_pc_step, in_acc, pc_reg == $past(pc_reg) + 32'd4)
    `RVD_ASSERT_IMP(a_target_valid, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])
    `RVD_ASSERT_IMP(a_invalid_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[41:0] == 42'd0 && m_axis_tdata[105:74] == 32'd0)
    `RVD_ASSERT_NXT(a_out_hold, out_valid_reg && !m_axis_tready, out_valid_reg && $stable(out_addr_reg))

endmodule
